### sv/ups_pkg.sv
// Package for the battery-backed supply supervisor: state, action, LED and register codes.
`timescale 1ns / 1ps

package ups_pkg;

	typedef enum logic [2:0] {
		ST_RUN          = 3'd0,
		ST_UNCLEAR      = 3'd1,
		ST_WARN_TO_RUN  = 3'd2,
		ST_SHUT_TO_RUN  = 3'd3,
		ST_WARN         = 3'd4,
		ST_WARN_TO_SHUT = 3'd5,
		ST_SHUT         = 3'd6
	} power_state_t;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_EVAL    = 3'd1,
		ACT_CONTACT = 3'd2,
		ACT_PRIMED  = 3'd3,
		ACT_CAUSE   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		LED_NONE     = 2'd0,
		LED_BG_OFF   = 2'd1,
		LED_BLINK_BG = 2'd2,
		LED_REBOOT   = 2'd3
	} led_t;

	typedef enum logic [2:0] {
		CFG_SHUTDOWN_MV = 3'd0,
		CFG_WARN_MV     = 3'd1,
		CFG_RESTART_MV  = 3'd2,
		CFG_TIMEOUT_S   = 3'd3,
		CFG_FORCE_OFF   = 3'd4
	} cfg_index_t;

	localparam logic [2:0]  CAUSE_HOST      = 3'b001;
	localparam logic [2:0]  CAUSE_BATTERY   = 3'b010;
	localparam logic [1:0]  PRIMED_ARMED    = 2'd1;
	localparam logic [1:0]  PRIMED_BUTTON   = 2'd2;
	localparam logic [15:0] SECONDS_MAX     = 16'hFFFF;

	localparam logic [15:0] RST_SHUTDOWN_MV = 16'd3200;
	localparam logic [15:0] RST_WARN_MV     = 16'd3400;
	localparam logic [15:0] RST_RESTART_MV  = 16'd3600;
	localparam logic [15:0] RST_TIMEOUT_S   = 16'd60;

endpackage

### sv/ups_power_state_controller.sv
// Top level of the supply supervisor: input register, state update pass and result register.
// Throughput: one word per cycle while the receiver keeps out_ready high; a stall holds
// the result register and then the input register. The single-pass state update allows it.
// Reset (arst_n low, asynchronous): state unclear, counter, primed level and causes zero,
// registers at their reset values, both pipeline stages empty.
`timescale 1ns / 1ps

module ups_power_state_controller
	import ups_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [15:0] battery_mv,
	input  logic        charger_present,
	input  logic [1:0]  primed_value,
	input  logic [2:0]  cause_bits,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  state_code,
	output logic [15:0] seconds_out,
	output logic        power_off_pulse,
	output logic        power_on_pulse,
	output logic        host_restart_pulse,
	output logic        shutdown_warning,
	output logic [1:0]  led_pattern
);

	// Configuration registers
	logic [15:0] shutdown_mv_q, warn_mv_q, restart_mv_q, timeout_s_q;
	logic        force_off_q;

	// Supervisor state
	power_state_t state_q;
	logic [15:0]  seconds_q;
	logic [1:0]   primed_q;
	logic [2:0]   causes_q;

	// Input register
	logic        valid_s1;
	logic [2:0]  action_s1;
	logic [15:0] mv_s1;
	logic        charger_s1;
	logic [1:0]  pval_s1;
	logic [2:0]  cbits_s1;

	logic advance;

	power_state_t state_d;
	logic [15:0]  seconds_d;
	logic [1:0]   primed_d;
	logic [2:0]   causes_d;
	logic         p_off_d, p_on_d, p_rst_d, warn_d;
	led_t         led_d;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shutdown_mv_q <= RST_SHUTDOWN_MV;
			warn_mv_q     <= RST_WARN_MV;
			restart_mv_q  <= RST_RESTART_MV;
			timeout_s_q   <= RST_TIMEOUT_S;
			force_off_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHUTDOWN_MV: shutdown_mv_q <= cfg_data;
				CFG_WARN_MV:     warn_mv_q     <= cfg_data;
				CFG_RESTART_MV:  restart_mv_q  <= cfg_data;
				CFG_TIMEOUT_S:   timeout_s_q   <= cfg_data;
				CFG_FORCE_OFF:   force_off_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action;
			mv_s1      <= battery_mv;
			charger_s1 <= charger_present;
			pval_s1    <= primed_value;
			cbits_s1   <= cause_bits;
		end
	end

	// One word's effect on the state. Every decision in an evaluate uses the
	// counter value held at the start of the word.
	always_comb begin
		state_d   = state_q;
		seconds_d = seconds_q;
		primed_d  = primed_q;
		causes_d  = causes_q;
		p_off_d   = 1'b0;
		p_on_d    = 1'b0;
		p_rst_d   = 1'b0;
		warn_d    = 1'b0;
		led_d     = LED_NONE;

		unique case (action_s1)
			ACT_TICK: begin
				if (seconds_q != SECONDS_MAX) begin
					seconds_d = seconds_q + 16'd1;
				end
			end
			ACT_EVAL: begin
				if (charger_s1) begin
					priority if (mv_s1 <= shutdown_mv_q) begin
						if (state_d < ST_WARN_TO_SHUT) begin
							state_d = ST_WARN_TO_SHUT;
						end
					end else if (mv_s1 <= warn_mv_q) begin
						if (state_d < ST_WARN) begin
							state_d  = ST_WARN;
							causes_d = causes_d | CAUSE_BATTERY;
						end
					end else if (mv_s1 <= restart_mv_q) begin
						if (state_d == ST_UNCLEAR && seconds_q > timeout_s_q) begin
							state_d = ST_WARN;
						end
					end else begin
						priority if (state_d == ST_SHUT || state_d == ST_WARN_TO_SHUT) begin
							state_d = ST_SHUT_TO_RUN;
						end else if (state_d == ST_WARN) begin
							state_d = ST_WARN_TO_RUN;
						end else if (state_d == ST_UNCLEAR) begin
							state_d = ST_RUN;
						end else begin
						end
					end
				end

				// The host gets the warning only for causes other than its own.
				if (state_d <= ST_WARN && !causes_d[0] && causes_d > CAUSE_HOST &&
				    seconds_q < timeout_s_q) begin
					warn_d = 1'b1;
				end

				if (state_d == ST_WARN_TO_SHUT) begin
					if (primed_q == PRIMED_ARMED && force_off_q) begin
						p_off_d = 1'b1;
						led_d   = LED_BG_OFF;
					end
					state_d = ST_SHUT;
				end

				priority if (state_d == ST_WARN) begin
					seconds_d = '0;
				end else if (state_d == ST_SHUT_TO_RUN) begin
					if (primed_q == PRIMED_ARMED) begin
						p_on_d = 1'b1;
						led_d  = LED_BLINK_BG;
					end
					seconds_d = '0;
					state_d   = ST_RUN;
					causes_d  = '0;
				end else if (state_d == ST_WARN_TO_RUN) begin
					state_d  = ST_RUN;
					causes_d = '0;
				end else begin
				end

				if (state_d == ST_RUN && seconds_q > timeout_s_q && primed_q != 2'd0) begin
					led_d   = LED_REBOOT;
					p_rst_d = 1'b1;
					if (primed_q == PRIMED_BUTTON) begin
						primed_d = 2'd0;
					end
					seconds_d = '0;
				end
			end
			ACT_CONTACT: begin
				if (state_q == ST_UNCLEAR) begin
					state_d = ST_RUN;
				end
				seconds_d = '0;
			end
			ACT_PRIMED: begin
				primed_d = pval_s1;
			end
			ACT_CAUSE: begin
				causes_d = causes_q | cbits_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_UNCLEAR;
			seconds_q <= '0;
			primed_q  <= '0;
			causes_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				state_q   <= state_d;
				seconds_q <= seconds_d;
				primed_q  <= primed_d;
				causes_q  <= causes_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_code         <= state_d;
			seconds_out        <= seconds_d;
			power_off_pulse    <= p_off_d;
			power_on_pulse     <= p_on_d;
			host_restart_pulse <= p_rst_d;
			shutdown_warning   <= warn_d;
			led_pattern        <= led_d;
		end
	end

`ifndef SYNTH
	// Transitional states are resolved within the evaluate that enters them.
	a_no_transient_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_WARN_TO_SHUT || state_q == ST_SHUT_TO_RUN ||
		  state_q == ST_WARN_TO_RUN))
		else $error("transitional power state was stored");

	a_power_on_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && power_on_pulse) |-> (state_code == ST_RUN && seconds_out == 16'd0))
		else $error("power on without entering run");

	a_power_off_shut: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && power_off_pulse) |-> (state_code == ST_SHUT))
		else $error("power off without entering shut");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && host_restart_pulse) |-> (seconds_out == 16'd0 && state_code == ST_RUN))
		else $error("host restart without clearing the counter");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("word accepted while both stages are full and stalled");
`endif

endmodule

### tb/sv/tb_ups_power_state_controller.sv
// Testbench for the supply supervisor: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_ups_power_state_controller;
	import ups_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [2:0]  state;
		logic [15:0] seconds;
		logic        p_off;
		logic        p_on;
		logic        p_rst;
		logic        warn;
		logic [1:0]  led;
	} supervisor_result_t;

	class supervisor_scoreboard;
		logic [15:0]  shut_mv, warn_mv, restart_mv, timeout_s;
		logic         force_off;
		power_state_t st;
		logic [15:0]  secs;
		logic [1:0]   primed;
		logic [2:0]   causes;
		supervisor_result_t expected_results[$];
		int errors;

		function new();
			shut_mv = RST_SHUTDOWN_MV;
			warn_mv = RST_WARN_MV;
			restart_mv = RST_RESTART_MV;
			timeout_s = RST_TIMEOUT_S;
			force_off = 1'b0;
			st = ST_UNCLEAR;
			secs = '0;
			primed = '0;
			causes = '0;
			errors = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [15:0] val);
			case (idx)
				CFG_SHUTDOWN_MV: shut_mv = val;
				CFG_WARN_MV:     warn_mv = val;
				CFG_RESTART_MV:  restart_mv = val;
				CFG_TIMEOUT_S:   timeout_s = val;
				CFG_FORCE_OFF:   force_off = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Works out the result of one accepted word and advances the predicted state.
		function void note_word(logic [2:0] act, logic [15:0] mv, logic chg,
				logic [1:0] pval, logic [2:0] cbits);
			supervisor_result_t r;
			logic [15:0] held;
			r.p_off = 1'b0;
			r.p_on = 1'b0;
			r.p_rst = 1'b0;
			r.warn = 1'b0;
			r.led = LED_NONE;
			held = secs;
			case (act)
				ACT_TICK: begin
					if (secs != SECONDS_MAX)
						secs = secs + 16'd1;
				end
				ACT_EVAL: begin
					if (chg) begin
						if (mv <= shut_mv) begin
							if (st < ST_WARN_TO_SHUT)
								st = ST_WARN_TO_SHUT;
						end else if (mv <= warn_mv) begin
							if (st < ST_WARN) begin
								st = ST_WARN;
								causes = causes | CAUSE_BATTERY;
							end
						end else if (mv <= restart_mv) begin
							if (st == ST_UNCLEAR && held > timeout_s)
								st = ST_WARN;
						end else begin
							if (st == ST_SHUT || st == ST_WARN_TO_SHUT)
								st = ST_SHUT_TO_RUN;
							else if (st == ST_WARN)
								st = ST_WARN_TO_RUN;
							else if (st == ST_UNCLEAR)
								st = ST_RUN;
						end
					end
					if (st <= ST_WARN && (causes & CAUSE_HOST) == 3'b000 &&
							causes > CAUSE_HOST && held < timeout_s)
						r.warn = 1'b1;
					if (st == ST_WARN_TO_SHUT) begin
						if (primed == PRIMED_ARMED && force_off) begin
							r.p_off = 1'b1;
							r.led = LED_BG_OFF;
						end
						st = ST_SHUT;
					end
					if (st == ST_WARN) begin
						secs = '0;
					end else if (st == ST_SHUT_TO_RUN) begin
						if (primed == PRIMED_ARMED) begin
							r.p_on = 1'b1;
							r.led = LED_BLINK_BG;
						end
						secs = '0;
						st = ST_RUN;
						causes = '0;
					end else if (st == ST_WARN_TO_RUN) begin
						st = ST_RUN;
						causes = '0;
					end
					// The restart decision uses the counter as it stood when the word arrived.
					if (st == ST_RUN && held > timeout_s && primed != 2'd0) begin
						r.led = LED_REBOOT;
						r.p_rst = 1'b1;
						if (primed == PRIMED_BUTTON)
							primed = 2'd0;
						secs = '0;
					end
				end
				ACT_CONTACT: begin
					if (st == ST_UNCLEAR)
						st = ST_RUN;
					secs = '0;
				end
				ACT_PRIMED: primed = pval;
				ACT_CAUSE:  causes = causes | cbits;
				default: ;
			endcase
			r.state = st;
			r.seconds = secs;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [2:0] state, logic [15:0] seconds, logic p_off,
				logic p_on, logic p_rst, logic warn, logic [1:0] led);
			supervisor_result_t e;
			if (expected_results.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (state !== e.state) begin
				$error("state_code: expected %0d, actual %0d", e.state, state);
				errors++;
			end
			if (seconds !== e.seconds) begin
				$error("seconds_out: expected %0d, actual %0d", e.seconds, seconds);
				errors++;
			end
			if (p_off !== e.p_off) begin
				$error("power_off_pulse: expected %0d, actual %0d", e.p_off, p_off);
				errors++;
			end
			if (p_on !== e.p_on) begin
				$error("power_on_pulse: expected %0d, actual %0d", e.p_on, p_on);
				errors++;
			end
			if (p_rst !== e.p_rst) begin
				$error("host_restart_pulse: expected %0d, actual %0d", e.p_rst, p_rst);
				errors++;
			end
			if (warn !== e.warn) begin
				$error("shutdown_warning: expected %0d, actual %0d", e.warn, warn);
				errors++;
			end
			if (led !== e.led) begin
				$error("led_pattern: expected %0d, actual %0d", e.led, led);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [15:0] battery_mv;
	logic        charger_present;
	logic [1:0]  primed_value;
	logic [2:0]  cause_bits;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  state_code;
	logic [15:0] seconds_out;
	logic        power_off_pulse;
	logic        power_on_pulse;
	logic        host_restart_pulse;
	logic        shutdown_warning;
	logic [1:0]  led_pattern;

	supervisor_scoreboard sb;
	int  cycles = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;
	int  calm_words = 0;

	ups_power_state_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.battery_mv(battery_mv),
		.charger_present(charger_present),
		.primed_value(primed_value),
		.cause_bits(cause_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.state_code(state_code),
		.seconds_out(seconds_out),
		.power_off_pulse(power_off_pulse),
		.power_on_pulse(power_on_pulse),
		.host_restart_pulse(host_restart_pulse),
		.shutdown_warning(shutdown_warning),
		.led_pattern(led_pattern)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[ups_power_state_controller] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_word(action, battery_mv, charger_present, primed_value, cause_bits);
		if (arst_n && out_valid && out_ready)
			sb.check_result(state_code, seconds_out, power_off_pulse, power_on_pulse,
				host_restart_pulse, shutdown_warning, led_pattern);
	end

	// Receiver: random stall bursts, calm stretches and one long hold-off on request.
	initial begin : receiver
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (quiet || calm_left > 0) begin
				if (calm_left > 0)
					calm_left--;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				calm_left = $urandom_range(20, 80);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 10) begin
				stall_left = $urandom_range(0, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(logic [2:0] act, logic [15:0] mv, logic chg,
			logic [1:0] pv, logic [2:0] cb);
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		battery_mv <= mv;
		charger_present <= chg;
		primed_value <= pv;
		cause_bits <= cb;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] s, logic [15:0] w, logic [15:0] r,
			logic [15:0] t, logic f);
		write_reg(CFG_SHUTDOWN_MV, s);
		write_reg(CFG_WARN_MV, w);
		write_reg(CFG_RESTART_MV, r);
		write_reg(CFG_TIMEOUT_S, t);
		write_reg(CFG_FORCE_OFF, {15'd0, f});
	endtask

	// Stops sending, lets every outstanding result come back, then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_mv();
		int v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 65535);
			1: v = int'(sb.shut_mv) + $urandom_range(0, 4) - 2;
			2: v = int'(sb.warn_mv) + $urandom_range(0, 4) - 2;
			3: v = int'(sb.restart_mv) + $urandom_range(0, 4) - 2;
			4: v = int'(sb.restart_mv) + $urandom_range(3, 400);
			default: v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	task automatic send_random(int count);
		int sent;
		int roll;
		logic [2:0] act;
		logic [1:0] pv;
		sent = 0;
		while (sent < count) begin
			if (!quiet) begin
				if (calm_words > 0)
					calm_words--;
				else if ($urandom_range(0, 99) < 2)
					calm_words = $urandom_range(20, 60);
				else if ($urandom_range(0, 99) < 12) begin
					@(negedge clk);
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 13) - 1) @(negedge clk);
				end
			end
			roll = $urandom_range(0, 99);
			if (roll < 34)
				act = ACT_TICK;
			else if (roll < 64)
				act = ACT_EVAL;
			else if (roll < 74)
				act = ACT_CONTACT;
			else if (roll < 85)
				act = ACT_PRIMED;
			else if (roll < 94)
				act = ACT_CAUSE;
			else
				act = 3'd5 + 3'($urandom_range(0, 2));
			roll = $urandom_range(0, 99);
			if (roll < 45)
				pv = PRIMED_ARMED;
			else if (roll < 75)
				pv = PRIMED_BUTTON;
			else if (roll < 90)
				pv = 2'd0;
			else
				pv = 2'd3;
			send_word(act, pick_mv(), $urandom_range(0, 99) < 85, pv,
				3'($urandom_range(0, 7)));
			// Unknown actions do nothing, so they do not count toward the total.
			if (act <= ACT_CAUSE)
				sent++;
		end
	endtask

	initial begin
		int s;
		int w;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = '0;
		battery_mv = '0;
		charger_present = 1'b0;
		primed_value = '0;
		cause_bits = '0;
		out_ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset thresholds 3200 / 3400 / 3600 and timeout 60.
		send_word(ACT_EVAL, 16'd3500, 1'b1, 2'd0, 3'd0);
		send_word(ACT_CONTACT, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_PRIMED, 16'd0, 1'b0, 2'd3, 3'd0);
		send_word(ACT_CAUSE, 16'd0, 1'b0, 2'd0, 3'd7);
		send_word(ACT_EVAL, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'hFFFF, 1'b1, 2'd3, 3'd7);
		send_word(ACT_EVAL, 16'd3400, 1'b1, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd3300, 1'b1, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd3200, 1'b1, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd3601, 1'b1, 2'd0, 3'd0);
		send_word(ACT_PRIMED, 16'd0, 1'b0, PRIMED_ARMED, 3'd0);
		send_word(3'd5, 16'hFFFF, 1'b1, 2'd3, 3'd7);
		send_word(3'd6, 16'hFFFF, 1'b1, 2'd3, 3'd7);
		send_word(3'd7, 16'hFFFF, 1'b1, 2'd3, 3'd7);
		send_word(ACT_EVAL, 16'd3000, 1'b1, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd4000, 1'b1, 2'd0, 3'd0);
		send_word(ACT_CAUSE, 16'd0, 1'b0, 2'd0, CAUSE_BATTERY);
		send_word(ACT_EVAL, 16'd0, 1'b0, 2'd0, 3'd0);
		drain();

		// Short timeout with forced power off: restart, forced off, and a power on
		// followed by a restart in the same word, where the reboot blink wins.
		write_all(16'd3200, 16'd3400, 16'd3600, 16'd1, 1'b1);
		send_word(ACT_PRIMED, 16'd0, 1'b0, PRIMED_BUTTON, 3'd0);
		send_word(ACT_TICK, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_TICK, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd3500, 1'b1, 2'd0, 3'd0);
		send_word(ACT_PRIMED, 16'd0, 1'b0, PRIMED_ARMED, 3'd0);
		send_word(ACT_EVAL, 16'd100, 1'b1, 2'd0, 3'd0);
		send_word(ACT_TICK, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_TICK, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd5000, 1'b1, 2'd0, 3'd0);
		send_word(ACT_CONTACT, 16'd0, 1'b0, 2'd0, 3'd0);
		drain();

		// The receiver holds off for a long stretch while words keep coming.
		write_all(16'd1000, 16'd2000, 16'd3000, 16'd3, 1'b1);
		hold_req = 1'b1;
		send_random(500);
		drain();

		write_all(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		send_random(250);
		drain();

		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_random(250);
		drain();

		repeat (3) begin
			s = $urandom_range(0, 4000);
			w = s + $urandom_range(0, 600);
			write_all(16'(s), 16'(w), 16'(w + $urandom_range(0, 600)),
				16'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
			send_random(160);
			drain();
		end

		// From here on neither side idles. A long run of ticks past the timeout
		// ends in a restart.
		quiet = 1'b1;
		write_all(16'd3200, 16'd3400, 16'd3600, 16'd64, 1'b1);
		send_word(ACT_CONTACT, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_PRIMED, 16'd0, 1'b0, PRIMED_ARMED, 3'd0);
		repeat (70)
			send_word(ACT_TICK, 16'd0, 1'b0, 2'd0, 3'd0);
		send_word(ACT_EVAL, 16'd3500, 1'b1, 2'd0, 3'd0);
		send_word(ACT_TICK, 16'd0, 1'b0, 2'd0, 3'd0);
		drain();
		write_reg(CFG_TIMEOUT_S, 16'hFFFE);
		send_word(ACT_EVAL, 16'd3500, 1'b1, 2'd0, 3'd0);
		drain();

		write_all(16'd1500, 16'd1800, 16'd2100, 16'd2, 1'b1);
		send_random(150);
		drain();
		repeat (10) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ups_power_state_controller] OK");
		else
			$display("[ups_power_state_controller] ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/ups_pkg.sv
sv/ups_power_state_controller.sv
tb/sv/tb_ups_power_state_controller.sv
